// ----- rtl/wcr_pkg.sv -----
// Shared types and constants for the windowed coverage ratio block.
package wcr_pkg;

  localparam int unsigned POS_BITS_DEF   = 32;
  localparam int unsigned COV_BITS_DEF   = 20;
  localparam int unsigned FRAC_BITS_DEF  = 16;
  localparam int unsigned SUM_BITS       = 40;
  localparam int unsigned WSUM_BITS      = 64;
  localparam int unsigned RATIO_INT_BITS = 32;
  localparam int unsigned CFG_IDX_BITS   = 3;
  localparam int unsigned CFG_DATA_BITS  = 32;
  localparam longint unsigned BOTH_ZERO_RATIO = 64'd500000;
  localparam int unsigned DEF_MAX_COV    = 100000;
  localparam int unsigned DEF_SUBST      = 50;
  localparam int unsigned DEF_TARGET     = 1000;
  localparam int unsigned QUEUE_DEPTH    = 4;
  localparam int unsigned QUEUE_AW       = 2;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_MIN_COV_FIRST   = 3'd0,
    CFG_MAX_COV_FIRST   = 3'd1,
    CFG_MIN_COV_SECOND  = 3'd2,
    CFG_MAX_COV_SECOND  = 3'd3,
    CFG_WINDOW_TARGET   = 3'd4,
    CFG_MIN_WINDOW_SPAN = 3'd5,
    CFG_ZERO_SUBSTITUTE = 3'd6
  } cfg_idx_t;

  typedef enum logic {
    OP_INTERVAL = 1'b0,
    OP_FLUSH    = 1'b1
  } op_t;

  typedef struct packed {
    logic        operation;
    logic        new_scaffold;
    logic [31:0] interval_start;
    logic [31:0] interval_end;
    logic [19:0] coverage_first;
    logic [19:0] coverage_second;
  } in_item_t;

  typedef struct packed {
    logic [31:0] window_start;
    logic [31:0] window_span;
    logic [31:0] valid_bases;
    logic [35:0] avg_cov_first;
    logic [35:0] avg_cov_second;
    logic [47:0] cov_ratio;
    logic        both_zero;
    logic        last_result;
  } out_item_t;

  // Closed window snapshot handed from the accumulator to the divider side.
  typedef struct packed {
    logic [31:0] start;
    logic [31:0] span;
    logic [31:0] valid;
    logic [39:0] sum1;
    logic [39:0] sum2;
    logic [63:0] wsum1;
    logic [63:0] wsum2;
    logic        last;
  } win_t;

  typedef enum logic [2:0] {
    BE_IDLE,
    BE_DIV_A1,
    BE_DIV_A2,
    BE_DIV_R,
    BE_HOLD
  } be_state_t;

endpackage

// ----- rtl/wcr_divider.sv -----
// Radix-2 restoring divider producing a saturated fixed-point quotient.
module wcr_divider #(
  parameter int unsigned FRAC_BITS = wcr_pkg::FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] num,
  input  logic [63:0] den,
  input  logic [63:0] limit,
  output logic        done,
  output logic [63:0] quot
);
  import wcr_pkg::*;

  localparam int unsigned QW = 64 + FRAC_BITS;
  localparam int unsigned CW = $clog2(QW + 1);

  logic [QW-1:0] dvd_r, dvd_nxt;
  logic [64:0]   rem_r, rem_nxt;
  logic [63:0]   den_r, lim_r;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt, done_r, done_nxt;
  logic [64:0]   shifted, diff;
  logic [QW-1:0] full_q;

  assign shifted = {rem_r[63:0], dvd_r[QW-1]};
  assign diff    = shifted - {1'b0, den_r};

  always_comb begin
    dvd_nxt  = dvd_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      dvd_nxt  = {num, {FRAC_BITS{1'b0}}};
      rem_nxt  = '0;
      cnt_nxt  = CW'(QW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!diff[64]) begin
        rem_nxt = diff;
        dvd_nxt = {dvd_r[QW-2:0], 1'b1};
      end else begin
        rem_nxt = shifted;
        dvd_nxt = {dvd_r[QW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
    if (start) begin
      den_r <= den;
      lim_r <= limit;
    end
  end

  assign full_q = dvd_r;
  assign done   = done_r;
  // Saturate: any quotient above the limit clamps.
  assign quot = ((full_q >> 64) != '0 || full_q[63:0] > lim_r) ? lim_r : full_q[63:0];

endmodule

// ----- rtl/wcr_front.sv -----
// Front end: configuration registers, interval test and window accumulation.
module wcr_front #(
  parameter int unsigned FRAC_BITS = wcr_pkg::FRAC_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [wcr_pkg::CFG_IDX_BITS-1:0]  cfg_idx,
  input  logic [wcr_pkg::CFG_DATA_BITS-1:0] cfg_data,
  input  logic                            in_push,
  input  wcr_pkg::in_item_t               in_data,
  output logic                            in_full,
  input  logic [2:0]                      q_free,
  output logic                            win_push,
  output wcr_pkg::win_t                   win_data,
  output logic [19:0]                     subst
);
  import wcr_pkg::*;

  localparam logic [31:0] PMAX = '1;
  localparam logic [39:0] SMAX = '1;
  localparam logic [63:0] WMAX = '1;

  logic [19:0] min1_r, max1_r, min2_r, max2_r, subst_r;
  logic [31:0] target_r, minspan_r;

  logic [39:0] s1_r, s2_r;
  logic [63:0] w1_r, w2_r;
  logic [31:0] vc_r, sc_r, sp_r;
  logic        sk_r;

  // Pipeline stage: length, validity and products.
  logic        p_v_r, p_op_r, p_ns_r, p_ok_r;
  logic [31:0] p_len_r, p_st_r;
  logic [19:0] p_c1_r, p_c2_r;
  logic [51:0] p_m1_r, p_m2_r;

  logic        acc;
  logic [31:0] len;
  logic        ok;
  logic        emit_a, emit_b;

  // Hold input while q_free is under two or an item's second window waits.
  assign in_full = (q_free < 3'd2) || (emit_a && emit_b);
  assign acc = in_push && !in_full;
  assign len = (in_data.interval_end >= in_data.interval_start) ?
               in_data.interval_end - in_data.interval_start : '0;
  assign ok  = (in_data.coverage_first >= min1_r || in_data.coverage_second >= min2_r) &&
               in_data.coverage_first <= max1_r && in_data.coverage_second <= max2_r;
  assign subst = subst_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min1_r <= '0; max1_r <= 20'(DEF_MAX_COV);
      min2_r <= '0; max2_r <= 20'(DEF_MAX_COV);
      target_r <= 32'(DEF_TARGET); minspan_r <= '0; subst_r <= 20'(DEF_SUBST);
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_MIN_COV_FIRST:   min1_r    <= cfg_data[19:0];
        CFG_MAX_COV_FIRST:   max1_r    <= cfg_data[19:0];
        CFG_MIN_COV_SECOND:  min2_r    <= cfg_data[19:0];
        CFG_MAX_COV_SECOND:  max2_r    <= cfg_data[19:0];
        CFG_WINDOW_TARGET:   target_r  <= cfg_data;
        CFG_MIN_WINDOW_SPAN: minspan_r <= cfg_data;
        CFG_ZERO_SUBSTITUTE: subst_r   <= cfg_data[19:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) p_v_r <= 1'b0;
    else        p_v_r <= acc;
    if (acc) begin
      p_op_r  <= in_data.operation;
      p_ns_r  <= in_data.new_scaffold;
      p_ok_r  <= ok;
      p_len_r <= len;
      p_st_r  <= in_data.interval_start;
      p_c1_r  <= in_data.coverage_first;
      p_c2_r  <= in_data.coverage_second;
      p_m1_r  <= in_data.coverage_first * len;
      p_m2_r  <= in_data.coverage_second * len;
    end
  end

  // Accumulate stage: base values after optional scaffold clear.
  logic [39:0] b_s1, b_s2;
  logic [63:0] b_w1, b_w2;
  logic [31:0] b_vc, b_sc, b_sp;
  logic        b_sk;
  logic [39:0] n_s1, n_s2;
  logic [63:0] n_w1, n_w2;
  logic [31:0] n_vc, n_sc, n_sp;
  logic        n_sk;
  logic [32:0] t_sc, t_vc;
  logic [40:0] t_s1, t_s2;
  logic [64:0] t_w1, t_w2;
  logic        close_b;
  win_t        snap_a, snap_b;

  always_comb begin
    snap_a = '{start: sk_r ? sp_r : '0, span: sc_r, valid: vc_r, sum1: s1_r,
               sum2: s2_r, wsum1: w1_r, wsum2: w2_r, last: 1'b1};
    emit_a = 1'b0; emit_b = 1'b0; close_b = 1'b0;
    b_s1 = s1_r; b_s2 = s2_r; b_w1 = w1_r; b_w2 = w2_r;
    b_vc = vc_r; b_sc = sc_r; b_sp = sp_r; b_sk = sk_r;
    n_s1 = s1_r; n_s2 = s2_r; n_w1 = w1_r; n_w2 = w2_r;
    n_vc = vc_r; n_sc = sc_r; n_sp = sp_r; n_sk = sk_r;
    t_sc = '0; t_vc = '0; t_s1 = '0; t_s2 = '0; t_w1 = '0; t_w2 = '0;
    if (p_v_r) begin
      if (p_op_r == OP_FLUSH) begin
        emit_a = (sc_r >= minspan_r);
        n_s1 = '0; n_s2 = '0; n_w1 = '0; n_w2 = '0;
        n_vc = '0; n_sc = '0; n_sp = '0; n_sk = 1'b0;
      end else begin
        if (p_ns_r) begin
          emit_a = (vc_r != '0) && (sc_r >= minspan_r);
          b_s1 = '0; b_s2 = '0; b_w1 = '0; b_w2 = '0;
          b_vc = '0; b_sc = '0; b_sp = '0; b_sk = 1'b0;
        end
        t_sc = {1'b0, b_sc} + {1'b0, p_len_r};
        n_sc = t_sc[32] ? PMAX : t_sc[31:0];
        n_sp = b_sk ? b_sp : p_st_r;
        n_sk = 1'b1;
        n_vc = b_vc; n_s1 = b_s1; n_s2 = b_s2; n_w1 = b_w1; n_w2 = b_w2;
        if (p_ok_r) begin
          t_vc = {1'b0, b_vc} + {1'b0, p_len_r};
          n_vc = t_vc[32] ? PMAX : t_vc[31:0];
          t_s1 = {1'b0, b_s1} + 41'(p_c1_r);
          n_s1 = t_s1[40] ? SMAX : t_s1[39:0];
          t_s2 = {1'b0, b_s2} + 41'(p_c2_r);
          n_s2 = t_s2[40] ? SMAX : t_s2[39:0];
          t_w1 = {1'b0, b_w1} + 65'(p_m1_r);
          n_w1 = t_w1[64] ? WMAX : t_w1[63:0];
          t_w2 = {1'b0, b_w2} + 65'(p_m2_r);
          n_w2 = t_w2[64] ? WMAX : t_w2[63:0];
        end
        if (n_vc >= target_r) begin
          close_b = 1'b1;
          emit_b = (n_sc >= minspan_r);
        end
      end
    end
    snap_b = '{start: n_sp, span: n_sc, valid: n_vc, sum1: n_s1, sum2: n_s2,
               wsum1: n_w1, wsum2: n_w2, last: 1'b1};
    snap_a.last = !emit_b;
    if (close_b) begin
      n_s1 = '0; n_s2 = '0; n_w1 = '0; n_w2 = '0;
      n_vc = '0; n_sc = '0; n_sp = '0; n_sk = 1'b0;
    end
  end

  // Second result of an item is registered and goes out in the next cycle.
  logic        hold_v_r;
  win_t        hold_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r <= '0; s2_r <= '0; w1_r <= '0; w2_r <= '0;
      vc_r <= '0; sc_r <= '0; sp_r <= '0; sk_r <= 1'b0;
      hold_v_r <= 1'b0;
    end else begin
      s1_r <= n_s1; s2_r <= n_s2; w1_r <= n_w1; w2_r <= n_w2;
      vc_r <= n_vc; sc_r <= n_sc; sp_r <= n_sp; sk_r <= n_sk;
      hold_v_r <= emit_a && emit_b;
    end
    hold_r <= snap_b;
  end

  always_comb begin
    win_push = 1'b0;
    win_data = snap_a;
    if (hold_v_r) begin
      win_push = 1'b1;
      win_data = hold_r;
    end else if (emit_a) begin
      win_push = 1'b1;
      win_data = snap_a;
    end else if (emit_b) begin
      win_push = 1'b1;
      win_data = snap_b;
    end
  end

endmodule

// ----- rtl/wcr_queue.sv -----
// Small queue of closed windows between the accumulator and the divider.
module wcr_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  wcr_pkg::win_t  wdata,
  input  logic           pop,
  output wcr_pkg::win_t  rdata,
  output logic           empty,
  output logic [2:0]     free
);
  import wcr_pkg::*;

  win_t mem_r [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wp_r, rp_r;
  logic [QUEUE_AW:0]   cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop)  rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + (QUEUE_AW+1)'(push) - (QUEUE_AW+1)'(pop);
    end
    if (push) mem_r[wp_r] <= wdata;
  end

  assign rdata = mem_r[rp_r];
  assign empty = (cnt_r == '0);
  assign free  = 3'(QUEUE_DEPTH) - 3'(cnt_r);

endmodule

// ----- rtl/wcr_back.sv -----
// Back end: substitutes zero sums, runs the three divisions, holds the result.
module wcr_back #(
  parameter int unsigned FRAC_BITS = wcr_pkg::FRAC_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_empty,
  input  wcr_pkg::win_t       q_data,
  output logic                q_pop,
  input  logic [19:0]         subst,
  output logic                out_empty,
  input  logic                out_pop,
  output wcr_pkg::out_item_t  out_data
);
  import wcr_pkg::*;

  localparam logic [63:0] AVG_LIM   = 64'((65'd1 << 36) - 1);
  localparam logic [63:0] RATIO_LIM = 64'((65'd1 << 48) - 1);

  be_state_t st_r, st_nxt;
  win_t      w_r;
  out_item_t res_r;
  logic [39:0] r1_r, r2_r;
  logic        bz_r;

  logic        d_start, d_done;
  logic [63:0] d_num, d_den, d_lim, d_q;

  wcr_divider #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk(clk), .rst_n(rst_n), .start(d_start), .num(d_num), .den(d_den),
    .limit(d_lim), .done(d_done), .quot(d_q)
  );

  // Zero-sum substitution.
  logic [39:0] a1, a2, sub40;
  always_comb begin
    sub40 = 40'(subst);
    a1 = q_data.sum1;
    a2 = q_data.sum2;
    if (a1 == '0) a1 = (a2 < sub40) ? a2 : sub40;
    if (a2 == '0) a2 = (a1 < sub40) ? a1 : sub40;
  end

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      BE_IDLE:   if (!q_empty) st_nxt = BE_DIV_A1;
      BE_DIV_A1: if (d_done) st_nxt = BE_DIV_A2;
      BE_DIV_A2: if (d_done) st_nxt = BE_DIV_R;
      BE_DIV_R:  if (d_done) st_nxt = BE_HOLD;
      BE_HOLD:   if (out_pop) st_nxt = BE_IDLE;
      default:   st_nxt = BE_IDLE;
    endcase
  end

  always_comb begin
    q_pop   = (st_r == BE_IDLE) && !q_empty;
    d_start = 1'b0;
    d_num   = w_r.wsum1;
    d_den   = 64'(w_r.valid);
    d_lim   = AVG_LIM;
    case (st_r)
      BE_IDLE: begin
        d_start = !q_empty;
        d_num   = q_data.wsum1;
        d_den   = 64'(q_data.valid);
      end
      BE_DIV_A1: begin
        d_start = d_done;
        d_num   = w_r.wsum2;
      end
      BE_DIV_A2: begin
        d_start = d_done;
        d_num   = 64'(r1_r);
        d_den   = 64'(r2_r);
        d_lim   = RATIO_LIM;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) st_r <= BE_IDLE;
    else        st_r <= st_nxt;
    if (q_pop) begin
      w_r  <= q_data;
      r1_r <= a1;
      r2_r <= a2;
      bz_r <= (q_data.sum1 == '0) && (q_data.sum2 == '0);
      res_r.window_start <= q_data.start;
      res_r.window_span  <= q_data.span;
      res_r.valid_bases  <= q_data.valid;
      res_r.both_zero    <= (q_data.sum1 == '0) && (q_data.sum2 == '0);
      res_r.last_result  <= q_data.last;
    end
    if (d_done) begin
      case (st_r)
        BE_DIV_A1: res_r.avg_cov_first  <= (w_r.valid == '0) ? '0 : d_q[35:0];
        BE_DIV_A2: res_r.avg_cov_second <= (w_r.valid == '0) ? '0 : d_q[35:0];
        BE_DIV_R: begin
          if (bz_r)             res_r.cov_ratio <= 48'(BOTH_ZERO_RATIO << FRAC_BITS);
          else if (r2_r == '0)  res_r.cov_ratio <= '1;
          else                  res_r.cov_ratio <= d_q[47:0];
        end
        default: ;
      endcase
    end
  end

  assign out_empty = (st_r != BE_HOLD);
  assign out_data  = res_r;

endmodule

// ----- rtl/windowed_coverage_ratio.sv -----
// Top level of the windowed coverage ratio block.
// Intervals are accepted one per cycle unless full; a two-stage front end
// tests and accumulates them and pushes each closed window into a
// four-entry queue. The back end turns a window into a result with one
// shared restoring divider doing three divisions of 80 steps each; full
// rises while the queue, less room kept for the front pipeline, cannot
// take two more windows, and for one cycle when an item closes two windows.
module windowed_coverage_ratio #(
  parameter int unsigned FRAC_BITS = wcr_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [wcr_pkg::CFG_IDX_BITS-1:0]  cfg_idx,
  input  logic [wcr_pkg::CFG_DATA_BITS-1:0] cfg_data,
  input  logic                              in_push,
  input  wcr_pkg::in_item_t                 in_data,
  output logic                              in_full,
  output logic                              out_empty,
  input  logic                              out_pop,
  output wcr_pkg::out_item_t                out_data
);
  import wcr_pkg::*;

  logic       win_push, q_pop, q_empty;
  win_t       win_data, q_data;
  logic [2:0] q_free, q_free_adj;
  logic [19:0] subst;
  logic       p1_r, p2_r;

  // Count items still in the front pipeline against the queue space.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_r <= 1'b0; p2_r <= 1'b0;
    end else begin
      p1_r <= in_push && !in_full;
      p2_r <= p1_r;
    end
  end
  assign q_free_adj = (q_free < 3'(2*(32'(p1_r) + 32'(p2_r)))) ? 3'd0 :
                      q_free - 3'(2*(32'(p1_r) + 32'(p2_r)));

  wcr_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_idx(cfg_idx),
    .cfg_data(cfg_data), .in_push(in_push), .in_data(in_data),
    .in_full(in_full), .q_free(q_free_adj), .win_push(win_push),
    .win_data(win_data), .subst(subst)
  );

  wcr_queue u_queue (
    .clk(clk), .rst_n(rst_n), .push(win_push), .wdata(win_data),
    .pop(q_pop), .rdata(q_data), .empty(q_empty), .free(q_free)
  );

  wcr_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk(clk), .rst_n(rst_n), .q_empty(q_empty), .q_data(q_data),
    .q_pop(q_pop), .subst(subst), .out_empty(out_empty),
    .out_pop(out_pop), .out_data(out_data)
  );

endmodule
